// ===== src/cicp_pkg.sv =====
// shared types and constants for the cycle pruner
package cicp_pkg;
  localparam int MAX_COLUMNS_DEF = 16;
  localparam int ROW_WEIGHT_DEF = 3;
  localparam int PAIR_LIMIT = 2;
  localparam logic [4:0] COLUMN_COUNT_RESET = 5'd16;

  localparam logic [1:0] MODE_TEST = 2'd0;
  localparam logic [1:0] MODE_PUSH = 2'd1;
  localparam logic [1:0] MODE_POP = 2'd2;
  localparam logic [1:0] MODE_NOP = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_POPRD,
    ST_POPUPD,
    ST_SUMM,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_FETCH,
    PH_PREP,
    PH_CHECK
  } scan_ph_t;

  typedef struct packed {
    logic load;
    logic do_push;
    logic scan_start;
    logic scan_step;
    logic pop_read;
    logic pop_apply;
    logic summarize;
  } cmd_t;

  typedef struct packed {
    logic is_test;
    logic is_push;
    logic is_pop;
    logic scan_last;
  } sts_t;
endpackage

// ===== src/cicp_if.sv =====
// valid/ready channel carrying a payload
interface cicp_in_if;
  logic valid;
  logic ready;
  logic [1:0] mode;
  logic [15:0] row_mask;
  modport source (output valid, mode, row_mask, input ready);
  modport sink (input valid, mode, row_mask, output ready);
endinterface

interface cicp_out_if;
  logic valid;
  logic ready;
  logic column_full;
  logic shares_pair;
  logic closes_long_cycle;
  logic can_finish;
  logic complete;
  logic refused;
  logic [4:0] depth_now;
  modport source (output valid, column_full, shares_pair, closes_long_cycle,
                  can_finish, complete, refused, depth_now, input ready);
  modport sink (input valid, column_full, shares_pair, closes_long_cycle,
                can_finish, complete, refused, depth_now, output ready);
endinterface

// ===== src/cicp_ctrl.sv =====
// controller state machine of the cycle pruner
module cicp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  cicp_pkg::sts_t  sts,
  output cicp_pkg::cmd_t  cmd
);
  cicp_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= cicp_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      cicp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = cicp_pkg::ST_SUMM;
        end
      end
      cicp_pkg::ST_SUMM: begin
        // first pass after load: dispatch by mode
        if (sts.is_test) begin
          cmd.scan_start = 1'b1;
          state_nxt = cicp_pkg::ST_SCAN;
        end else if (sts.is_push) begin
          cmd.do_push = 1'b1;
          state_nxt = cicp_pkg::ST_POPUPD;
        end else if (sts.is_pop) begin
          cmd.pop_read = 1'b1;
          state_nxt = cicp_pkg::ST_POPRD;
        end else begin
          state_nxt = cicp_pkg::ST_POPUPD;
        end
      end
      cicp_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) state_nxt = cicp_pkg::ST_POPUPD;
      end
      cicp_pkg::ST_POPRD: begin
        cmd.pop_apply = 1'b1;
        state_nxt = cicp_pkg::ST_POPUPD;
      end
      cicp_pkg::ST_POPUPD: begin
        cmd.summarize = 1'b1;
        state_nxt = cicp_pkg::ST_OUT;
      end
      cicp_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = cicp_pkg::ST_IDLE;
      end
      default: state_nxt = cicp_pkg::ST_IDLE;
    endcase
  end
endmodule

// ===== src/cicp_dp.sv =====
// datapath: row stack, column loads and fault checks
module cicp_dp #(
  parameter int MAX_COLUMNS = cicp_pkg::MAX_COLUMNS_DEF,
  parameter int ROW_WEIGHT = cicp_pkg::ROW_WEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [4:0]            cfg_wdata,
  input  logic [1:0]            mode,
  input  logic [15:0]           row_mask,
  input  cicp_pkg::cmd_t        cmd,
  output cicp_pkg::sts_t        sts,
  output logic                  column_full,
  output logic                  shares_pair,
  output logic                  closes_long_cycle,
  output logic                  can_finish,
  output logic                  complete,
  output logic                  refused,
  output logic [4:0]            depth_now
);
  localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int DW = $clog2(MAX_COLUMNS + 1);
  localparam int LW = $clog2(ROW_WEIGHT + 1);
  localparam int RW = (MAX_COLUMNS < 16) ? MAX_COLUMNS : 16;
  localparam logic [MAX_COLUMNS-1:0] LSB = MAX_COLUMNS'(1);

  logic [4:0] ccount_r;
  logic [DW-1:0] depth_r;
  logic [1:0] mode_r;
  logic [MAX_COLUMNS-1:0] row_r;
  logic [MAX_COLUMNS-1:0] stack_mem [MAX_COLUMNS];
  logic [LW-1:0] load_r [MAX_COLUMNS];
  logic [MAX_COLUMNS-1:0] top_r;
  logic [DW-1:0] eff_m;
  logic [MAX_COLUMNS-1:0] mcol;
  logic [DW-1:0] idx_r;
  cicp_pkg::scan_ph_t ph_r;
  logic [MAX_COLUMNS-1:0] arow_r;
  logic [MAX_COLUMNS-1:0] srem_r;
  logic [MAX_COLUMNS-1:0] sbit_r;
  logic [MAX_COLUMNS-1:0] thr_r;
  logic [MAX_COLUMNS-1:0] cov1_r;
  logic [MAX_COLUMNS-1:0] cov2_r;
  logic full_r, pair_r, cyc_r, ref_r, fin_r, done_r;

  always_comb begin
    if ({27'd0, ccount_r} > MAX_COLUMNS) eff_m = DW'(MAX_COLUMNS);
    else eff_m = DW'(ccount_r);
    for (int j = 0; j < MAX_COLUMNS; j++) mcol[j] = (j < int'(eff_m));
  end

  assign sts.is_test = (mode_r == cicp_pkg::MODE_TEST);
  assign sts.is_push = (mode_r == cicp_pkg::MODE_PUSH);
  assign sts.is_pop = (mode_r == cicp_pkg::MODE_POP);
  assign sts.scan_last = (ph_r == cicp_pkg::PH_FETCH) && (idx_r >= depth_r);

  always_ff @(posedge clk) begin
    if (!rst_n) ccount_r <= cicp_pkg::COLUMN_COUNT_RESET;
    else if (cfg_we) ccount_r <= cfg_wdata;
  end

  // stack memory and top read
  always_ff @(posedge clk) begin
    if (cmd.do_push && depth_r < eff_m) stack_mem[depth_r[AW-1:0]] <= row_r;
    if (cmd.pop_read && depth_r != '0) top_r <= stack_mem[AW'(depth_r - 1'b1)];
  end

  // test scan walks the first path row; second and third rows checked in parallel
  always_ff @(posedge clk) begin
    logic [MAX_COLUMNS-1:0] arow, sb, above, acc1, acc2, thr, x, y;
    arow = '0;
    sb = '0;
    above = '0;
    acc1 = '0;
    acc2 = '0;
    thr = '0;
    x = '0;
    y = '0;
    if (!rst_n) begin
      depth_r <= '0;
      for (int j = 0; j < MAX_COLUMNS; j++) load_r[j] <= '0;
    end else begin
      if (cmd.load) begin
        mode_r <= mode;
        row_r <= MAX_COLUMNS'(row_mask[RW-1:0]) & mcol;
        full_r <= 1'b0;
        pair_r <= 1'b0;
        cyc_r <= 1'b0;
        ref_r <= 1'b0;
        idx_r <= '0;
      end
      if (cmd.do_push) begin
        if (depth_r >= eff_m) ref_r <= 1'b1;
        else begin
          depth_r <= depth_r + 1'b1;
          for (int j = 0; j < MAX_COLUMNS; j++)
            if (row_r[j] && load_r[j] < LW'(ROW_WEIGHT)) load_r[j] <= load_r[j] + 1'b1;
        end
      end
      if (cmd.pop_read) begin
        if (depth_r == '0) ref_r <= 1'b1;
        else depth_r <= depth_r - 1'b1;
      end
      if (cmd.pop_apply && !ref_r) begin
        for (int j = 0; j < MAX_COLUMNS; j++)
          if (top_r[j] && load_r[j] != '0) load_r[j] <= load_r[j] - 1'b1;
      end
      if (cmd.scan_start) begin
        for (int j = 0; j < MAX_COLUMNS; j++)
          if (row_r[j] && load_r[j] >= LW'(ROW_WEIGHT)) full_r <= 1'b1;
        idx_r <= '0;
        ph_r <= cicp_pkg::PH_FETCH;
      end
      if (cmd.scan_step) begin
        unique case (ph_r)
          cicp_pkg::PH_FETCH: begin
            if (idx_r < depth_r) begin
              arow = stack_mem[idx_r[AW-1:0]];
              if ($countones(arow & row_r) >= cicp_pkg::PAIR_LIMIT) pair_r <= 1'b1;
              arow_r <= arow;
              srem_r <= arow & row_r;
              ph_r <= cicp_pkg::PH_PREP;
            end
          end
          cicp_pkg::PH_PREP: begin
            if (srem_r == '0) begin
              idx_r <= idx_r + 1'b1;
              ph_r <= cicp_pkg::PH_FETCH;
            end else begin
              // lowest start column left, rows reaching a later candidate column
              sb = srem_r & (~srem_r + LSB);
              above = ~(sb | (sb - LSB));
              for (int c = 0; c < MAX_COLUMNS; c++)
                if (DW'(c) < depth_r && DW'(c) != idx_r &&
                    (stack_mem[c] & row_r & above) != '0) begin
                  thr[c] = 1'b1;
                  acc2 = acc2 | (acc1 & stack_mem[c]);
                  acc1 = acc1 | stack_mem[c];
                end
              sbit_r <= sb;
              srem_r <= srem_r & ~sb;
              thr_r <= thr;
              cov1_r <= acc1;
              cov2_r <= acc2;
              ph_r <= cicp_pkg::PH_CHECK;
            end
          end
          cicp_pkg::PH_CHECK: begin
            for (int b = 0; b < MAX_COLUMNS; b++)
              if (DW'(b) < depth_r && DW'(b) != idx_r) begin
                x = arow_r & stack_mem[b] & ~sbit_r;
                y = stack_mem[b] & (thr_r[b] ? cov2_r : cov1_r) & ~sbit_r;
                if (x != '0 && y != '0 && !(x == y && (x & (x - LSB)) == '0))
                  cyc_r <= 1'b1;
              end
            ph_r <= cicp_pkg::PH_PREP;
          end
          default: ph_r <= cicp_pkg::PH_FETCH;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [DW-1:0] rem;
    logic f, d;
    if (cmd.summarize) begin
      rem = (depth_r >= eff_m) ? '0 : eff_m - depth_r;
      f = 1'b1;
      d = (depth_r == eff_m);
      for (int j = 0; j < MAX_COLUMNS; j++)
        if (mcol[j]) begin
          if ({{(DW+1){1'b0}}, load_r[j]} + {{(LW+1){1'b0}}, rem} <
              (DW+LW+1)'(ROW_WEIGHT)) f = 1'b0;
          if (load_r[j] != LW'(ROW_WEIGHT)) d = 1'b0;
        end
      fin_r <= f;
      done_r <= d;
    end
  end

  assign column_full = full_r;
  assign shares_pair = pair_r;
  assign closes_long_cycle = cyc_r;
  assign can_finish = fin_r;
  assign complete = done_r;
  assign refused = ref_r;
  assign depth_now = 5'(depth_r);
endmodule

// ===== src/cubic_incidence_cycle_pruner_top.sv =====
// top level of the cubic incidence cycle pruner
// usage: requests arrive on the in channel (mode, row_mask); a test checks a
// candidate row, a push stores it, a pop removes the top row. one result per
// request leaves on the out channel and is held until taken.
// path of a request through the states, from its accept to its result:
// push and the unused mode go through dispatch, summary and output, a pop
// adds a read of the top row after dispatch, and a test adds the cycle check;
// the cycle check fetches each stored row in turn and, for each candidate
// column that row holds, prepares and then checks it.
// one request is in flight at a time; the next one is accepted the cycle
// after the result is taken.
// a stalled receiver holds the result and the input stays not ready.
// reset clears the depth, the column loads and sets the column count to 16.
// cfg_we writes the column count; the user must assert it only while the block is idle, the block does not enforce it.
module cubic_incidence_cycle_pruner_top #(
  parameter int MAX_COLUMNS = cicp_pkg::MAX_COLUMNS_DEF,
  parameter int ROW_WEIGHT = cicp_pkg::ROW_WEIGHT_DEF
) (
  input logic clk,
  input logic rst_n,
  input logic cfg_we,
  input logic [4:0] cfg_wdata,
  cicp_in_if.sink in_ch,
  cicp_out_if.source out_ch
);
  cicp_pkg::cmd_t cmd;
  cicp_pkg::sts_t sts;

  cicp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .sts(sts), .cmd(cmd)
  );

  cicp_dp #(.MAX_COLUMNS(MAX_COLUMNS), .ROW_WEIGHT(ROW_WEIGHT)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .mode(in_ch.mode), .row_mask(in_ch.row_mask), .cmd(cmd), .sts(sts),
    .column_full(out_ch.column_full), .shares_pair(out_ch.shares_pair),
    .closes_long_cycle(out_ch.closes_long_cycle), .can_finish(out_ch.can_finish),
    .complete(out_ch.complete), .refused(out_ch.refused),
    .depth_now(out_ch.depth_now)
  );
endmodule
